// ----- design/stcl_pkg.sv -----
// Package for the sorted table codepoint lookup block.
// Holds table geometry, opcode values and the entry and result structs.
// No dependencies.
package stcl_pkg;

    localparam int TABLE_DEPTH  = 65536;
    localparam int OFFSET_WIDTH = 24;

    localparam int KEY_W   = 21;
    localparam int LIDX_W  = 16;
    localparam int OUT_OFS_W = 24;
    localparam int COUNT_W = 17;
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int BOUND_W = ADDR_W + 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [OFFSET_WIDTH-1:0] name_ofs;
        logic [OFFSET_WIDTH-1:0] annot_ofs;
    } entry_t;

    typedef struct packed {
        logic                    found;
        logic [ADDR_W-1:0]       idx;
        logic [OFFSET_WIDTH-1:0] name_ofs;
        logic [OFFSET_WIDTH-1:0] annot_ofs;
    } result_t;

endpackage

// ----- design/stcl_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the lookup table; no package dependency.
module stcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/stcl_search.sv -----
// Binary search sequencer: one shared probe/compare step per iteration.
// Depends on stcl_pkg; reads the table through the RAM port in the top level.
module stcl_search
    import stcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KEY_W-1:0]   key,
    input  logic [BOUND_W-1:0] count,
    output logic               busy,
    output logic [ADDR_W-1:0]  rd_addr,
    input  entry_t             rd_data,
    output logic               done,
    output result_t            result,
    input  logic               done_ack
);

    typedef enum logic [1:0] {S_IDLE, S_PROBE, S_WAIT, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [BOUND_W-1:0] lo_reg, lo_next;
    logic [BOUND_W-1:0] hi_reg, hi_next;
    logic [BOUND_W-1:0] mid_reg, mid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    result_t            res_reg, res_next;
    logic [BOUND_W-1:0] mid;

    // midpoint of the live window, rounded down
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        rd_addr    = mid[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    key_next   = key;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_WAIT;
                end
                else
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_WAIT:
            begin
                if (rd_data.key == key_reg)
                begin
                    res_next.found     = 1'b1;
                    res_next.idx       = mid_reg[ADDR_W-1:0];
                    res_next.name_ofs  = rd_data.name_ofs;
                    res_next.annot_ofs = rd_data.annot_ofs;
                    state_next         = S_DONE;
                end
                else if (key_reg < rd_data.key)
                begin
                    hi_next    = mid_reg;
                    state_next = S_PROBE;
                end
                else
                begin
                    lo_next    = mid_reg + BOUND_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

endmodule

// ----- design/sorted_table_codepoint_lookup.sv -----
// Sorted table codepoint lookup: load entries, binary-search them by key.
// Loads are accepted one per cycle, back to back, while no search runs. A lookup
// makes at most ceil(log2(n+1)) probes over n entries (17 for 65536), each one a
// midpoint read then a key compare; a miss ends on an empty window. The next word
// is taken once the result enters the output register; output stalls delay that.
// Reset clears control state and entry_count; the table is undefined until loaded.
module sorted_table_codepoint_lookup
    import stcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 opcode,
    input  logic [LIDX_W-1:0]    load_index,
    input  logic [KEY_W-1:0]     codepoint,
    input  logic [OUT_OFS_W-1:0] name_offset,
    input  logic [OUT_OFS_W-1:0] annot_offset,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [LIDX_W-1:0]    hit_index,
    output logic [OUT_OFS_W-1:0] name_position,
    output logic [OUT_OFS_W-1:0] annotation_position,
    // entry_count write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COUNT_W-1:0]   cfg_data
);

    logic [COUNT_W-1:0] entry_count_reg;
    logic [BOUND_W-1:0] search_count;

    logic               in_take;
    logic               load_we;
    logic               lookup_start;
    logic               busy;
    logic [ADDR_W-1:0]  srch_addr;
    logic [ADDR_W-1:0]  ram_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic               srch_done;
    result_t            srch_result;
    logic               res_load;

    logic               out_valid_reg;
    result_t            out_res_reg;

    // config register: always ready; a search copies the count when it starts
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // clamp the searched range to the table depth
    assign search_count = (32'(entry_count_reg) > 32'(TABLE_DEPTH))
                        ? BOUND_W'(TABLE_DEPTH)
                        : BOUND_W'(entry_count_reg);

    // hold off new words while a search runs; loads go straight to the RAM
    assign in_stall     = busy;
    assign in_take      = in_valid && !in_stall;
    assign load_we      = in_take && (opcode == OP_LOAD)
                          && (32'(load_index) < 32'(TABLE_DEPTH));
    assign lookup_start = in_take && (opcode == OP_LOOKUP);

    assign wr_entry.key       = codepoint;
    assign wr_entry.name_ofs  = OFFSET_WIDTH'(name_offset);
    assign wr_entry.annot_ofs = OFFSET_WIDTH'(annot_offset);

    // one RAM port: load address while idle, probe address while searching
    assign ram_addr = busy ? srch_addr : ADDR_W'(load_index);

    stcl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .addr  (ram_addr),
        .wdata (wr_entry),
        .rdata (rd_entry)
    );

    stcl_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lookup_start),
        .key      (codepoint),
        .count    (search_count),
        .busy     (busy),
        .rd_addr  (srch_addr),
        .rd_data  (rd_entry),
        .done     (srch_done),
        .result   (srch_result),
        .done_ack (res_load)
    );

    // output register: advance a finished result when the slot is free or drains
    assign res_load = srch_done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= srch_result;
        end
    end

    assign out_valid           = out_valid_reg;
    assign found               = out_res_reg.found;
    assign hit_index           = LIDX_W'(out_res_reg.idx);
    assign name_position       = OUT_OFS_W'(out_res_reg.name_ofs);
    assign annotation_position = OUT_OFS_W'(out_res_reg.annot_ofs);

endmodule
